// File: sv/hs_pkg.sv
// Package: sizes, cell link types and controller states of the heap sorter.
`timescale 1ns / 1ps
package hs_pkg;

  // Number of values one set can hold
  localparam int CAPACITY = 64;
  // Width of the fill count, which must also hold CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // Controller state
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } hs_state_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } hs_ctrl_t;

  // Status one cell hands to its upper neighbour
  typedef struct packed {
    logic occ;  // cell holds a value
    logic le;   // held value is not greater than the incoming one
  } hs_link_t;

endpackage

// File: sv/hs_in_if.sv
// Interface: input channel carrying one value and its last marker.
`timescale 1ns / 1ps
interface hs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// File: sv/hs_out_if.sv
// Interface: output channel carrying one sorted value with its flags.
`timescale 1ns / 1ps
interface hs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_res;
  logic               last_res;
  logic               dropped;

  modport source (output valid, output value_res, output last_res, output dropped,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input dropped,
                  output ready);
endinterface

// File: sv/hs_cell.sv
// Module: one sorting cell holding a single value of the ascending row.
`timescale 1ns / 1ps
module hs_cell (
  input  logic                            clk_i,
  input  hs_pkg::hs_ctrl_t                ctrl_i,
  input  logic signed [hs_pkg::VAL_W-1:0] ins_i,
  input  logic                            occ_i,
  input  hs_pkg::hs_link_t                prev_i,
  input  logic signed [hs_pkg::VAL_W-1:0] prev_val_i,
  input  logic signed [hs_pkg::VAL_W-1:0] next_val_i,
  output hs_pkg::hs_link_t                link_o,
  output logic signed [hs_pkg::VAL_W-1:0] val_o
);
  import hs_pkg::*;

  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    le;

  // Compare the held value against the broadcast one
  assign le        = occ_i && (val_q <= ins_i);
  assign link_o.occ = occ_i;
  assign link_o.le  = le;
  assign val_o      = val_q;

  // Keep, take from below, take the new value, or pass downwards when draining
  always_comb begin
    val_d = val_q;
    if (ctrl_i.drain) begin
      val_d = next_val_i;
    end else if (ctrl_i.insert && !le) begin
      if (prev_i.occ && !prev_i.le) begin
        val_d = prev_val_i;
      end else if (prev_i.occ && prev_i.le) begin
        val_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: sv/heap_sort_core.sv
// Top level: row of sorting cells with fill/drain controller and output register.
//
// Usage: values enter on in_ch, one transaction each. Every accepted value is
// placed at once into an ascending row of CAPACITY cells; in_ch.ready stays
// high while a set is being collected. A value that arrives while the row is
// full is discarded and the set is marked as having dropped data. The
// transaction with last set closes the set (it is inserted too when there is
// room); the block then shifts the row down by one cell per cycle while out_ch
// does not stall and sends the values on out_ch in ascending order, the last
// one with last_res set, each with dropped showing whether the set lost data.
// Once the closing transaction is accepted, the controller drains the row,
// moving each result from cell zero into the output register.
// While draining, in_ch.ready is low. A stall on out_ch holds the output
// register and freezes the row; the next set may start while the final result
// still waits in the output register. Reset empties the row (fill count to
// zero), clears the dropped flag and the output valid, and returns to filling.
`timescale 1ns / 1ps
module heap_sort_core (
  input  logic clk_i,
  input  logic rst_ni,
  hs_in_if.sink    in_ch,
  hs_out_if.source out_ch
);
  import hs_pkg::*;

  hs_state_e          state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_val_q;
  logic               out_last_q, out_drop_q;

  logic               in_ready;
  logic               in_acc;
  logic               full;
  logic               load;
  logic               load_last;
  hs_ctrl_t           ctrl;

  logic signed [VAL_W-1:0] cell_val  [CAPACITY];
  hs_link_t                cell_link [CAPACITY];

  assign in_acc    = in_ch.valid && in_ready;
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign load_last = (count_q == CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL:  if (in_acc && in_ch.last) state_d = ST_DRAIN;
      ST_DRAIN: if (load && load_last) state_d = ST_FILL;
      default:  state_d = ST_FILL;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready    = 1'b0;
    load        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.drain  = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready    = 1'b1;
        ctrl.insert = in_ch.valid && !full;
      end
      ST_DRAIN: begin
        load       = !out_valid_q || out_ch.ready;
        ctrl.drain = load;
      end
      default: ;
    endcase
  end

  // Fill count and dropped flag
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctrl.insert) count_d = count_q + CNT_W'(1);
    if (in_acc && full) ovf_d = 1'b1;
    if (load) begin
      count_d = count_q - CNT_W'(1);
      if (load_last) ovf_d = 1'b0;
    end
  end

  // Hold the result until the receiver takes it
  assign out_valid_d = load || (out_valid_q && !out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_val_q  <= cell_val[0];
      out_last_q <= load_last;
      out_drop_q <= ovf_q;
    end
  end

  // Row of cells, lowest value in cell zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hs_link_t                prev_link;
    logic signed [VAL_W-1:0] prev_val;
    logic signed [VAL_W-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_link = '{occ: 1'b1, le: 1'b1};
      assign prev_val  = in_ch.value;
    end else begin : g_inner
      assign prev_link = cell_link[i-1];
      assign prev_val  = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_val = '0;
    end else begin : g_below
      assign next_val = cell_val[i+1];
    end

    hs_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .ins_i      (in_ch.value),
      .occ_i      (count_q > CNT_W'(i)),
      .prev_i     (prev_link),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .link_o     (cell_link[i]),
      .val_o      (cell_val[i])
    );
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_q;
  assign out_ch.value_res = out_val_q;
  assign out_ch.last_res  = out_last_q;
  assign out_ch.dropped   = out_drop_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_no_input_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !in_ch.ready)
    else $error("input taken while draining");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (count_q != '0))
    else $error("draining an empty row");

  a_final_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && load_last) |=> (count_q == '0 && !ovf_q && state_q == ST_FILL))
    else $error("final result did not empty the row");

  a_drop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> ovf_q)
    else $error("dropped value not recorded");
`endif

endmodule

// File: test/tb_heap_sort_core.sv
// Testbench: heap sorter checked set by set against an ascending-order predictor.
`timescale 1ns / 1ps
module tb_heap_sort_core;
  import hs_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction before giving up
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 20;    // settle time after the last result
  localparam int TARGET_ITEMS = 410;
  localparam int CALM_ITEMS   = 60;    // closing stretch without idling

  // One expected output transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    dropped;
  } sorted_beat_t;

  // Keeps the values of the open set in ascending order and queues the sorted run
  class sorted_order_tracker;
    logic signed [VAL_W-1:0] held[CAPACITY];
    int           held_cnt = 0;
    bit           overflow = 0;
    sorted_beat_t expected_sorted[$];
    int           mismatches = 0;
    int           n_values = 0;
    int           n_sets = 0;
    int           n_results = 0;
    int           n_overflow_sets = 0;

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function int pending();
      return expected_sorted.size();
    endfunction

    // Record an accepted input; on a closing transaction queue the whole run
    function void note_value(logic signed [VAL_W-1:0] v, logic is_last);
      int j;
      int k;
      sorted_beat_t beat;
      n_values++;
      if (held_cnt >= CAPACITY) begin
        overflow = 1'b1;
      end else begin
        j = held_cnt;
        while (j > 0 && held[j-1] > v) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = v;
        held_cnt++;
      end
      if (is_last) begin
        for (k = 0; k < held_cnt; k++) begin
          beat.value   = held[k];
          beat.last    = (k == held_cnt - 1);
          beat.dropped = overflow;
          expected_sorted.push_back(beat);
        end
        n_sets++;
        if (overflow) n_overflow_sets++;
        held_cnt = 0;
        overflow = 1'b0;
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    task check_sorted_out(logic signed [VAL_W-1:0] v, logic l, logic d);
      sorted_beat_t beat;
      n_results++;
      if (expected_sorted.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", v));
      end else begin
        beat = expected_sorted.pop_front();
        if (v !== beat.value)
          report_mismatch($sformatf("value_res %0d, want %0d", v, beat.value));
        if (l !== beat.last)
          report_mismatch($sformatf("last_res %b, want %b (value %0d)", l, beat.last,
                                    beat.value));
        if (d !== beat.dropped)
          report_mismatch($sformatf("dropped %b, want %b (value %0d)", d, beat.dropped,
                                    beat.value));
      end
    endtask
  endclass

  logic clk;
  logic rst_ni;

  hs_in_if  in_ch ();
  hs_out_if out_ch ();

  heap_sort_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_order_tracker sb = new();

  bit send_idle = 1'b1;   // sender may insert gaps
  bit recv_idle = 1'b1;   // receiver may insert gaps
  bit hold_req  = 1'b0;   // ask the receiver for one long hold-off
  int items_sent = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a value: random words, small numbers, extremes and repeats
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $signed(32'($urandom_range(0, 16))) - 32'sd8;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      2: v = $signed(32'($urandom_range(0, 3))) * 32'sd1000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic signed [VAL_W-1:0] v, logic l);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(v, l);
    items_sent++;
  endtask

  // Send a set of random values, the final one closing it
  task automatic send_set(int n);
    int i;
    for (i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  // Stop offering until every queued result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random set size: mostly short, now and then medium, at or past capacity
  function automatic int pick_set_size();
    case ($urandom_range(0, 19))
      0: return CAPACITY + $urandom_range(0, 6);
      1: return $urandom_range(20, CAPACITY);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Receiver: check results and drive ready with gaps and one long hold
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_ch.valid && out_ch.ready)
        sb.check_sorted_out(out_ch.value_res, out_ch.last_res, out_ch.dropped);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int set_idx;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rst_ni      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: single-value sets at both extremes
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
    // Extremes and alternating bit patterns in one set
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b1);
    // Equal values
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b1);
    wait_drained();

    // Exactly full, then the closing value itself dropped, then several dropped
    send_set(CAPACITY);
    send_set(CAPACITY + 1);
    send_set(CAPACITY + 6);

    // Long receiver hold while the sender keeps offering
    wait_drained();
    hold_req = 1'b1;
    send_set(12);
    send_set(5);

    // Sender pause until everything has come out
    wait_drained();

    // Random sets, idling switched off now and then
    set_idx = 0;
    while (items_sent < TARGET_ITEMS - CALM_ITEMS) begin
      send_idle = (set_idx % 5 != 4);
      recv_idle = (set_idx % 5 != 4);
      send_set(pick_set_size());
      if ($urandom_range(0, 15) == 0) wait_drained();
      set_idx++;
    end

    // Closing stretch without idling
    send_idle = 1'b0;
    recv_idle = 1'b0;
    while (items_sent < TARGET_ITEMS) send_set($urandom_range(1, 12));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d values in %0d sets (%0d sets overflowed), %0d results checked",
             sb.n_values, sb.n_sets, sb.n_overflow_sets, sb.n_results);
    $display("including a %0d-cycle output hold-off and full-capacity sets",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
sv/hs_pkg.sv
sv/hs_in_if.sv
sv/hs_out_if.sv
sv/hs_cell.sv
sv/heap_sort_core.sv
test/tb_heap_sort_core.sv
